// ===== rtl/core/min_priority_queue_core_assert.svh =====
// Assertion macros used by the heap queue checker.
`ifndef MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mpq_pkg.sv =====
// Shared constants, codes and types of the min-heap priority queue.
package mpq_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_BITS_DEF = 32;

	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 11;

	typedef enum logic [0:0] {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_UP,
		S_PUSH_ROOT,
		S_POP_LOAD,
		S_POP_DOWN,
		S_DONE
	} state_t;

endpackage

// ===== rtl/core/mpq_req_if.sv =====
// Request channel: one word carries a push or pop operation.
interface mpq_req_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [mpq_pkg::KEY_W-1:0] key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

// ===== rtl/core/mpq_rsp_if.sv =====
// Response channel: one word carries the result of one operation.
interface mpq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mpq_pkg::KEY_W-1:0]    out_key;
	logic [mpq_pkg::STATUS_W-1:0] status;
	logic [mpq_pkg::FILL_W-1:0]   fill_level;

	modport source (output valid, output out_key, output status, output fill_level, input ready);
	modport sink   (input valid, input out_key, input status, input fill_level, output ready);
endinterface

// ===== rtl/core/mpq_ram.sv =====
// Heap storage: one write port and two read ports with registered read data.
module mpq_ram #(
	parameter int DEPTH = mpq_pkg::CAPACITY_DEF,
	parameter int WIDTH = mpq_pkg::KEY_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/core/min_priority_queue_core.sv =====
// Top level of the binary min-heap priority queue.
//
//   channel  dir  word fields                      meaning
//   req      in   func, key                        push a key or pop the minimum
//   rsp      out  out_key, status, fill_level      popped key, status, keys held
//
// One operation is in flight at a time. A push opens a hole at the next free position
// and climbs: each step compares the new key with its parent, read from the memory in
// the step before, and moves a larger parent into the hole until the key settles or
// reaches the root. A pop reads the root and the last entry together, then sinks the
// last entry from the root, moving the smaller child up. A dropped push and an empty pop
// only report status. Reset clears only the fill count and control state, since only
// held entries are ever read; a finished result waits while the output word is untaken.
module min_priority_queue_core #(
	parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mpq_req_if.sink    req,
	mpq_rsp_if.source  rsp
);

	localparam int AddrW = $clog2(CAPACITY);
	localparam int CntW  = $clog2(CAPACITY + 1);
	localparam int PosW  = CntW + 1;
	localparam int KeyW  = mpq_pkg::KEY_W;
	localparam int FillW = mpq_pkg::FILL_W;

	// Heap positions count from 1 at the root; memory slot is position minus one.
	function automatic logic [AddrW-1:0] slot(input logic [PosW-1:0] p);
		logic [PosW-1:0] t;
		t = p - 1'b1;
		return t[AddrW-1:0];
	endfunction

	mpq_pkg::state_t  state_q, state_d;
	logic [CntW-1:0]  cnt_q, cnt_d;
	logic [CntW-1:0]  pos_q, pos_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [KEY_BITS-1:0] res_key_q, res_key_d;
	mpq_pkg::status_t res_status_q, res_status_d;

	logic                 out_valid_q;
	logic [KeyW-1:0]      out_key_q;
	mpq_pkg::status_t     out_status_q;
	logic [FillW-1:0]     out_fill_q;
	logic                 out_load;

	logic                 ram_we;
	logic [AddrW-1:0]     ram_waddr;
	logic [KEY_BITS-1:0]  ram_wdata;
	logic [AddrW-1:0]     raddr_a, raddr_b;
	logic [KEY_BITS-1:0]  rdata_a, rdata_b;

	logic                 accept;
	logic                 is_pop;
	logic                 is_full;
	logic                 is_empty;
	logic [CntW-1:0]      cnt_inc;
	logic [CntW-1:0]      parent;
	logic                 up_larger;
	logic [PosW-1:0]      child_l, child_r, cnt_ext;
	logic                 has_l, has_r, take_r, dn_swap;
	logic [PosW-1:0]      pick;
	logic [CntW-1:0]      pick_pos;
	logic [KEY_BITS-1:0]  pick_key;
	logic [KEY_BITS-1:0]  in_key;

	mpq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(KEY_BITS)
	) u_mpq_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign accept   = req.valid && req.ready;
	assign is_pop   = (req.func == mpq_pkg::FUNC_POP);
	assign is_full  = (cnt_q == CntW'(CAPACITY));
	assign is_empty = (cnt_q == '0);
	assign cnt_inc  = cnt_q + 1'b1;
	assign in_key   = KEY_BITS'(req.key);

	// Sift-up: the parent value read last cycle is compared with the climbing key.
	assign parent    = pos_q >> 1;
	assign up_larger = (rdata_a > key_q);

	// Sift-down: both children were read last cycle. On a tie the right child wins.
	assign child_l  = {pos_q, 1'b0};
	assign child_r  = {pos_q, 1'b1};
	assign cnt_ext  = PosW'(cnt_q);
	assign has_l    = (child_l <= cnt_ext);
	assign has_r    = (child_r <= cnt_ext);
	assign take_r   = has_r && !(rdata_a < rdata_b);
	assign pick     = take_r ? child_r : child_l;
	assign pick_pos = pick[CntW-1:0];
	assign pick_key = take_r ? rdata_b : rdata_a;
	assign dn_swap  = has_l && (pick_key < key_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpq_pkg::S_IDLE: begin
				if (req.valid) begin
					if (is_pop) begin
						state_d = is_empty ? mpq_pkg::S_DONE : mpq_pkg::S_POP_LOAD;
					end else if (is_full || is_empty) begin
						state_d = mpq_pkg::S_DONE;
					end else begin
						state_d = mpq_pkg::S_PUSH_UP;
					end
				end
			end
			mpq_pkg::S_PUSH_UP: begin
				if (!up_larger) begin
					state_d = mpq_pkg::S_DONE;
				end else if (parent == CntW'(1)) begin
					state_d = mpq_pkg::S_PUSH_ROOT;
				end
			end
			mpq_pkg::S_PUSH_ROOT: begin
				state_d = mpq_pkg::S_DONE;
			end
			mpq_pkg::S_POP_LOAD: begin
				state_d = is_empty ? mpq_pkg::S_DONE : mpq_pkg::S_POP_DOWN;
			end
			mpq_pkg::S_POP_DOWN: begin
				if (!dn_swap) begin
					state_d = mpq_pkg::S_DONE;
				end
			end
			mpq_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = mpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpq_pkg::S_IDLE;
			end
		endcase
	end

	// Memory accesses and datapath updates for each state.
	always_comb begin
		req.ready    = (state_q == mpq_pkg::S_IDLE);
		ram_we       = 1'b0;
		ram_waddr    = slot(PosW'(pos_q));
		ram_wdata    = key_q;
		raddr_a      = '0;
		raddr_b      = '0;
		cnt_d        = cnt_q;
		pos_d        = pos_q;
		key_d        = key_q;
		res_key_d    = res_key_q;
		res_status_d = res_status_q;
		out_load     = 1'b0;
		unique case (state_q)
			mpq_pkg::S_IDLE: begin
				if (accept) begin
					res_key_d    = '0;
					res_status_d = mpq_pkg::ST_OK;
					if (is_pop) begin
						if (is_empty) begin
							res_status_d = mpq_pkg::ST_EMPTY;
						end else begin
							// Fetch the root and the last entry together.
							raddr_a = slot(PosW'(1));
							raddr_b = slot(PosW'(cnt_q));
							cnt_d   = cnt_q - 1'b1;
						end
					end else if (is_full) begin
						res_status_d = mpq_pkg::ST_FULL;
					end else begin
						cnt_d = cnt_inc;
						pos_d = cnt_inc;
						key_d = in_key;
						if (is_empty) begin
							ram_we    = 1'b1;
							ram_waddr = slot(PosW'(1));
							ram_wdata = in_key;
						end else begin
							raddr_a = slot(PosW'(cnt_inc >> 1));
						end
					end
				end
			end
			mpq_pkg::S_PUSH_UP: begin
				ram_we = 1'b1;
				if (up_larger) begin
					// Move the parent down into the hole and fetch the next parent.
					ram_wdata = rdata_a;
					pos_d     = parent;
					raddr_a   = slot(PosW'(parent >> 1));
				end
			end
			mpq_pkg::S_PUSH_ROOT: begin
				ram_we = 1'b1;
			end
			mpq_pkg::S_POP_LOAD: begin
				res_key_d = rdata_a;
				key_d     = rdata_b;
				pos_d     = CntW'(1);
				raddr_a   = slot(PosW'(2));
				raddr_b   = slot(PosW'(3));
			end
			mpq_pkg::S_POP_DOWN: begin
				ram_we = 1'b1;
				if (dn_swap) begin
					// Move the smaller child up into the hole and fetch its children.
					ram_wdata = pick_key;
					pos_d     = pick_pos;
					raddr_a   = slot({pick_pos, 1'b0});
					raddr_b   = slot({pick_pos, 1'b1});
				end
			end
			mpq_pkg::S_DONE: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpq_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		key_q        <= key_d;
		res_key_q    <= res_key_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_key_q    <= KeyW'(res_key_q);
			out_status_q <= res_status_q;
			out_fill_q   <= FillW'(cnt_q);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_key    = out_key_q;
	assign rsp.status     = out_status_q;
	assign rsp.fill_level = out_fill_q;

endmodule

// ===== rtl/core/mpq_checker.sv =====
// Port-level assertions for the heap queue core and the bind that attaches them.
`include "min_priority_queue_core_assert.svh"

module mpq_checker #(
	parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [mpq_pkg::KEY_W-1:0]    out_key,
	input logic [mpq_pkg::STATUS_W-1:0] status,
	input logic [mpq_pkg::FILL_W-1:0]   fill_level
);

	localparam int FillW = mpq_pkg::FILL_W;

	`MPQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(out_key) && $stable(status) && $stable(fill_level), "response word changed while stalled")
	`MPQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready, "second word taken while an operation is in flight")
	`MPQ_ASSERT_SAME(a_empty_pop, clk, arst_n, rsp_valid && (status == mpq_pkg::ST_EMPTY), (out_key == '0) && (fill_level == '0), "empty pop reported a key or a nonzero fill level")
	`MPQ_ASSERT_SAME(a_full_push, clk, arst_n, rsp_valid && (status == mpq_pkg::ST_FULL), (out_key == '0) && (fill_level == FillW'(CAPACITY)), "dropped push reported while not full")

endmodule

bind min_priority_queue_core mpq_checker #(
	.CAPACITY(CAPACITY)
) u_mpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_key   (rsp.out_key),
	.status    (rsp.status),
	.fill_level(rsp.fill_level)
);
